/* hdl/top_k_weight_normalizer_top_defines.svh */
// ----------------------------------------------------------------------------
// top_k_weight_normalizer_top_defines
// Assertion macros shared by the top-k weight normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_WEIGHT_NORMALIZER_TOP_DEFINES_SVH
`define TOP_K_WEIGHT_NORMALIZER_TOP_DEFINES_SVH

// consequence must hold in the same cycle as the antecedent
`define TKWN_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence must hold in the cycle after the antecedent
`define TKWN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/tkwn_pkg.sv */
// ----------------------------------------------------------------------------
// tkwn_pkg
// Types and constants for the top-k weight normalizer.
// ----------------------------------------------------------------------------
package tkwn_pkg;

	localparam int WEIGHT_W   = 48;
	localparam int JOINT_W    = 6;
	localparam int SHARE_W    = 17;
	localparam int SLOT_W     = 2;
	localparam int KCFG_W     = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 32;
	localparam int STEP_CW    = 5;

	localparam int SLOT_COUNT_DEF      = 4;
	localparam int JOINT_COUNT_MAX_DEF = 64;

	localparam logic [CFG_IDX_W-1:0] REG_INFLUENCES_USED = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_WEIGHT      = 1'd1;

	localparam logic [KCFG_W-1:0]     INFLUENCES_RESET = 3'd4;
	localparam logic [CFG_DATA_W-1:0] MIN_WEIGHT_RESET = 16'd1;

	localparam logic [SHARE_W-1:0] ONE_Q16   = 17'h10000;
	localparam logic [STEP_CW-1:0] DIV_STEPS = 5'd17;

	typedef struct packed {
		logic                valid;
		logic [WEIGHT_W-1:0] weight;
		logic [JOINT_W-1:0]  joint;
	} cell_data_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_mode_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* hdl/tkwn_cell.sv */
// ----------------------------------------------------------------------------
// tkwn_cell
// One entry of the sorted list: compares the incoming weight with its own,
// takes the left neighbor or the new item on insert, the right one on shift.
// ----------------------------------------------------------------------------
module tkwn_cell
	import tkwn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_mode_t mode,
	input  cell_data_t new_item,
	input  cell_data_t left,
	input  logic       left_greater,
	input  cell_data_t right,
	output cell_data_t own,
	output logic       greater
);

	cell_data_t data_q;
	cell_data_t data_d;

	// strict compare keeps an equal weight behind the earlier one
	assign greater = !data_q.valid || (new_item.weight > data_q.weight);
	assign own     = data_q;

	always_comb begin
		data_d = data_q;
		case (mode)
			CELL_INSERT: begin
				if (greater) begin
					data_d = left_greater ? left : new_item;
				end
			end
			CELL_SHIFT: data_d = right;
			default:    data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_d;
		end
	end

endmodule

/* hdl/tkwn_div.sv */
// ----------------------------------------------------------------------------
// tkwn_div
// Bit-serial restoring divider: round(dividend * 65536 / divisor), one
// quotient bit per cycle, then a rounding step. Needs dividend <= divisor.
// ----------------------------------------------------------------------------
`include "top_k_weight_normalizer_top_defines.svh"

module tkwn_div
	import tkwn_pkg::*;
#(
	parameter int SUM_W = WEIGHT_W + 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [WEIGHT_W-1:0] dividend,
	input  logic [SUM_W-1:0]    divisor,
	output logic [SHARE_W-1:0]  quotient,
	output div_stat_t           stat
);

	logic                busy_q;
	logic                done_q;
	logic [STEP_CW-1:0]  cnt_q;
	logic [SUM_W:0]      r_q;
	logic [SHARE_W-1:0]  q_q;
	logic                r_ge;
	logic [SUM_W:0]      diff;

	assign r_ge = r_q >= {1'b0, divisor};
	assign diff = r_ge ? (r_q - {1'b0, divisor}) : r_q;

	assign quotient  = q_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			q_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
				r_q    <= (SUM_W + 1)'(dividend);
				q_q    <= '0;
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					r_q   <= {diff[SUM_W-1:0], 1'b0};
					q_q   <= {q_q[SHARE_W-2:0], r_ge};
					cnt_q <= cnt_q - STEP_CW'(1);
				end else begin
					// r_q holds twice the remainder: round half up
					q_q    <= q_q + SHARE_W'(r_ge);
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	`TKWN_ASSERT_HOLDS(a_done_not_busy, done_q, !busy_q, "divider done while busy")
	`TKWN_ASSERT_NEXT(a_start_busy, start, busy_q, "divider did not start")
	`TKWN_ASSERT_NEXT(a_round_done, busy_q && cnt_q == '0 && !start, done_q, "rounding missed")

endmodule

/* hdl/top_k_weight_normalizer_top.sv */
// ----------------------------------------------------------------------------
// top_k_weight_normalizer_top
// Keeps the strongest joint weights of a vertex in a row of sorting cells and
// emits them normalized to Q1.16 on the last weight.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one joint weight per beat; tlast marks the vertex's last
//   weight. A non-last weight leaves the block collecting, so weights stream at one
//   per cycle while the block is collecting.
//   After the last beat s_axis_tready drops while the list is drained:
//   the cells first rotate through the adder for the sum, then each slot
//   is divided when it is bound (the serial divider takes one quotient
//   bit a cycle, 17 bits plus a rounding step) and skips the divider
//   when it is empty. m_axis gives SLOT_COUNT beats, tlast on the final
//   one; the block is ready for the next vertex the cycle after that beat is
//   loaded into the output register.
//   A stalled m_axis holds the output register and stops the drain.
//   Reset empties the list, sets influences_used to 4 and min_weight to 1.
//   Write the configuration port only while no vertex is in progress.
// ----------------------------------------------------------------------------
`include "top_k_weight_normalizer_top_defines.svh"

module top_k_weight_normalizer_top
	import tkwn_pkg::*;
#(
	parameter int SLOT_COUNT      = SLOT_COUNT_DEF,
	parameter int JOINT_COUNT_MAX = JOINT_COUNT_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// joint_id[5:0], raw_weight[53:6], fallback_joint[59:54], zero pad
	input  logic [S_TDATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// slot[1:0], bound_joint[7:2], share[24:8], zero pad
	output logic [M_TDATA_W-1:0]  m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int CW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int KW    = $clog2(SLOT_COUNT + 1);
	localparam int SUM_W = WEIGHT_W + KW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV,
		ST_WAIT,
		ST_PUSH
	} state_t;

	state_t                state_q;
	logic [KCFG_W-1:0]     influences_used_q;
	logic [CFG_DATA_W-1:0] min_weight_q;
	logic [KW-1:0]         k_q;
	logic [JOINT_W-1:0]    fb_q;
	logic [SUM_W-1:0]      sum_q;
	logic [CW-1:0]         slot_q;
	logic [JOINT_W-1:0]    res_joint_q;
	logic [SHARE_W-1:0]    res_share_q;
	logic                  out_valid_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [JOINT_W-1:0]    out_joint_q;
	logic [SHARE_W-1:0]    out_share_q;
	logic                  out_last_q;

	logic [JOINT_W-1:0]  in_joint;
	logic [WEIGHT_W-1:0] in_weight;
	logic [JOINT_W-1:0]  in_fb;
	logic                in_beat;
	logic                keep;
	logic                out_load;
	logic                last_slot;
	logic                slot_used;
	logic                div_start;
	logic [SHARE_W-1:0]  div_q;
	div_stat_t           div_stat;
	cell_mode_t          cell_mode;
	cell_data_t          new_item;
	cell_data_t          tail_in;
	cell_data_t          head;

	cell_data_t            cells    [SLOT_COUNT];
	cell_data_t            left_in  [SLOT_COUNT];
	cell_data_t            right_in [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] greater;
	logic [SLOT_COUNT-1:0] left_gt;
	logic [SLOT_COUNT-1:0] valid_vec;

	assign in_joint  = s_axis_tdata[JOINT_W-1:0];
	assign in_weight = s_axis_tdata[JOINT_W +: WEIGHT_W];
	assign in_fb     = s_axis_tdata[JOINT_W + WEIGHT_W +: JOINT_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign keep          = (32'(in_joint) < 32'(JOINT_COUNT_MAX))
		&& (in_weight > WEIGHT_W'(min_weight_q));

	assign new_item.valid  = 1'b1;
	assign new_item.weight = in_weight;
	assign new_item.joint  = in_joint;

	assign head      = cells[0];
	assign out_load  = (state_q == ST_PUSH) && (!out_valid_q || m_axis_tready);
	assign last_slot = (slot_q == CW'(SLOT_COUNT - 1));
	assign slot_used = (sum_q != '0) && head.valid && (32'(slot_q) < 32'(k_q));
	assign div_start = (state_q == ST_DIV) && slot_used;

	// rotate during the sum pass, fill with empty entries while draining
	assign tail_in = (state_q == ST_SUM) ? head : '0;

	always_comb begin
		case (state_q)
			ST_IDLE: cell_mode = (in_beat && keep) ? CELL_INSERT : CELL_HOLD;
			ST_SUM:  cell_mode = CELL_SHIFT;
			ST_PUSH: cell_mode = out_load ? CELL_SHIFT : CELL_HOLD;
			default: cell_mode = CELL_HOLD;
		endcase
	end

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_in[i] = '0;
			assign left_gt[i] = 1'b0;
		end else begin : g_inner
			assign left_in[i] = cells[i-1];
			assign left_gt[i] = greater[i-1];
		end
		if (i == SLOT_COUNT - 1) begin : g_tail
			assign right_in[i] = tail_in;
		end else begin : g_body
			assign right_in[i] = cells[i+1];
		end
		assign valid_vec[i] = cells[i].valid;

		tkwn_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.mode         (cell_mode),
			.new_item     (new_item),
			.left         (left_in[i]),
			.left_greater (left_gt[i]),
			.right        (right_in[i]),
			.own          (cells[i]),
			.greater      (greater[i])
		);

		if (i > 0) begin : g_chk
			`TKWN_ASSERT_HOLDS(a_prefix, state_q == ST_IDLE && cells[i].valid, cells[i-1].valid, "list gap")
		end
	end

	tkwn_div #(
		.SUM_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (head.weight),
		.divisor  (sum_q),
		.quotient (div_q),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			influences_used_q <= INFLUENCES_RESET;
			min_weight_q      <= MIN_WEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INFLUENCES_USED: influences_used_q <= cfg_wdata[KCFG_W-1:0];
				REG_MIN_WEIGHT:      min_weight_q      <= cfg_wdata;
				default:             min_weight_q      <= min_weight_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			fb_q        <= '0;
			sum_q       <= '0;
			slot_q      <= '0;
			res_joint_q <= '0;
			res_share_q <= '0;
			out_valid_q <= 1'b0;
			out_slot_q  <= '0;
			out_joint_q <= '0;
			out_share_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_slot_q  <= SLOT_W'(slot_q);
				out_joint_q <= res_joint_q;
				out_share_q <= res_share_q;
				out_last_q  <= last_slot;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_beat && s_axis_tlast) begin
						// clamp k to 1..SLOT_COUNT
						if (influences_used_q == '0) begin
							k_q <= KW'(1);
						end else if (32'(influences_used_q) > 32'(SLOT_COUNT)) begin
							k_q <= KW'(SLOT_COUNT);
						end else begin
							k_q <= KW'(influences_used_q);
						end
						fb_q    <= (32'(in_fb) < 32'(JOINT_COUNT_MAX)) ? in_fb : '0;
						sum_q   <= '0;
						slot_q  <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (head.valid && (32'(slot_q) < 32'(k_q))) begin
						sum_q <= sum_q + SUM_W'(head.weight);
					end
					if (last_slot) begin
						slot_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						slot_q <= slot_q + CW'(1);
					end
				end
				ST_DIV: begin
					if (slot_used) begin
						res_joint_q <= head.joint;
						state_q     <= ST_WAIT;
					end else begin
						if (sum_q == '0 && slot_q == '0) begin
							res_joint_q <= fb_q;
							res_share_q <= ONE_Q16;
						end else begin
							res_joint_q <= '0;
							res_share_q <= '0;
						end
						state_q <= ST_PUSH;
					end
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						res_share_q <= div_q;
						state_q     <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_load) begin
						if (last_slot) begin
							slot_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							slot_q  <= slot_q + CW'(1);
							state_q <= ST_DIV;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = M_TDATA_W'({out_share_q, out_joint_q, out_slot_q});
	assign m_axis_tlast  = out_last_q;

	`TKWN_ASSERT_NEXT(a_vertex_cleared, out_load && last_slot, valid_vec == '0, "list not cleared")
	`TKWN_ASSERT_HOLDS(a_wait_divisor, state_q == ST_WAIT, sum_q != '0, "divide by zero sum")
	`TKWN_ASSERT_HOLDS(a_div_free, div_start, !div_stat.busy, "divider started while busy")

endmodule

/* test/top_k_weight_normalizer_top_tb.sv */
// ----------------------------------------------------------------------------
// top_k_weight_normalizer_top_tb
// Streams joint weights of many vertices into the top-k normalizer and checks
// every slot beat against a cycle-free predictor of the sorted list and the
// rounded Q1.16 shares, across several influences_used / min_weight settings
// with random idling on both stream sides in all but one setting.
// ----------------------------------------------------------------------------
module top_k_weight_normalizer_top_tb
	import tkwn_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_PERIOD = 5;
	localparam int MAX_INF     = SLOT_COUNT_DEF;
	localparam int JOINT_MAX   = JOINT_COUNT_MAX_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_GAP   = 40;
	localparam int TAIL_GAP    = 150;
	localparam int PHASE_ITEMS = 33;

	typedef struct {
		logic [JOINT_W-1:0]  joint;
		logic [WEIGHT_W-1:0] weight;
		logic [JOINT_W-1:0]  fallback;
		logic                last;
	} weight_beat_t;

	typedef struct {
		logic [SLOT_W-1:0]  slot;
		logic [JOINT_W-1:0] joint;
		logic [SHARE_W-1:0] share;
		logic               last;
	} slot_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	// joint_id[5:0], raw_weight[53:6], fallback_joint[59:54], zero pad
	logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	// slot[1:0], bound_joint[7:2], share[24:8], zero pad
	logic [M_TDATA_W-1:0]  m_axis_tdata;
	logic                  m_axis_tlast;

	top_k_weight_normalizer_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// predictor state and its copy of the registers
	logic [WEIGHT_W-1:0]   kept_w [MAX_INF];
	logic [JOINT_W-1:0]    kept_j [MAX_INF];
	int unsigned           kept_n;
	logic [KCFG_W-1:0]     cur_k;
	logic [CFG_DATA_W-1:0] cur_min;

	weight_beat_t feed_q[$];
	slot_result_t slot_expect_q[$];
	weight_beat_t beat;
	slot_result_t got_slot;
	slot_result_t want_slot;

	int unsigned src_idle_pct = 30;
	int unsigned snk_idle_pct = 30;
	int unsigned items_queued = 0;
	int unsigned items_fed    = 0;
	int unsigned vertices     = 0;
	int unsigned slots_seen   = 0;
	int unsigned settings     = 1;
	int unsigned counted      = 0;
	int unsigned err_count    = 0;
	int unsigned cycle_count  = 0;
	logic [WEIGHT_W-1:0] prev_w = '0;

	always #(HALF_PERIOD) clk = ~clk;

	function automatic logic [SHARE_W-1:0] share_q16(logic [WEIGHT_W-1:0] w, logic [65:0] sum);
		logic [65:0] num;
		logic [65:0] q;
		logic [65:0] r;
		num = {18'd0, w} << 16;
		q = num / sum;
		r = num % sum;
		if ((r << 1) >= sum) begin
			q = q + 66'd1;
		end
		return q[SHARE_W-1:0];
	endfunction

	task automatic absorb_weight(logic [JOINT_W-1:0] j, logic [WEIGHT_W-1:0] w);
		int unsigned pos;
		int unsigned i;
		pos = 0;
		if (int'(j) >= JOINT_MAX || w <= {32'd0, cur_min}) begin
			return;
		end
		while (pos < kept_n && kept_w[pos] >= w) begin
			pos++;
		end
		if (pos >= MAX_INF) begin
			return;
		end
		i = (kept_n < MAX_INF) ? kept_n : MAX_INF - 1;
		while (i > pos) begin
			kept_w[i] = kept_w[i-1];
			kept_j[i] = kept_j[i-1];
			i--;
		end
		kept_w[pos] = w;
		kept_j[pos] = j;
		if (kept_n < MAX_INF) begin
			kept_n++;
		end
	endtask

	task automatic close_vertex(logic [JOINT_W-1:0] fb);
		int unsigned k;
		int unsigned n;
		logic [65:0] sum;
		slot_result_t res;
		k = cur_k;
		if (k < 1) begin
			k = 1;
		end
		if (k > MAX_INF) begin
			k = MAX_INF;
		end
		n = (kept_n < k) ? kept_n : k;
		sum = '0;
		for (int s = 0; s < n; s++) begin
			sum = sum + {18'd0, kept_w[s]};
		end
		for (int s = 0; s < MAX_INF; s++) begin
			res.slot  = SLOT_W'(s);
			res.joint = '0;
			res.share = '0;
			res.last  = (s == MAX_INF - 1);
			if (sum != 0) begin
				if (s < n) begin
					res.joint = kept_j[s];
					res.share = share_q16(kept_w[s], sum);
				end
			end else if (s == 0) begin
				res.joint = (int'(fb) < JOINT_MAX) ? fb : '0;
				res.share = ONE_Q16;
			end
			slot_expect_q.insert(slot_expect_q.size(), res);
		end
		for (int s = 0; s < MAX_INF; s++) begin
			kept_w[s] = '0;
			kept_j[s] = '0;
		end
		kept_n = 0;
		vertices++;
	endtask

	// sender: present the next pending beat, idling at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (feed_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				beat = feed_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {4'd0, beat.fallback, beat.weight, beat.joint};
				s_axis_tlast  <= beat.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver: stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// monitor: predict on accepted weights, check accepted slots
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				absorb_weight(s_axis_tdata[5:0], s_axis_tdata[53:6]);
				if (s_axis_tlast) begin
					close_vertex(s_axis_tdata[59:54]);
				end
				items_fed++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_slot.slot  = m_axis_tdata[1:0];
				got_slot.joint = m_axis_tdata[7:2];
				got_slot.share = m_axis_tdata[24:8];
				got_slot.last  = m_axis_tlast;
				slots_seen++;
				if (slot_expect_q.size() == 0) begin
					$error("slot beat with nothing expected: slot %0d joint %0d share %0d",
						got_slot.slot, got_slot.joint, got_slot.share);
					err_count++;
				end else begin
					want_slot = slot_expect_q.pop_front();
					if (got_slot.slot !== want_slot.slot) begin
						$error("slot: expected %0d, got %0d", want_slot.slot, got_slot.slot);
						err_count++;
					end
					if (got_slot.joint !== want_slot.joint) begin
						$error("bound_joint: expected %0d, got %0d",
							want_slot.joint, got_slot.joint);
						err_count++;
					end
					if (got_slot.share !== want_slot.share) begin
						$error("share: expected %0d, got %0d", want_slot.share, got_slot.share);
						err_count++;
					end
					if (got_slot.last !== want_slot.last) begin
						$error("last_slot: expected %0d, got %0d", want_slot.last, got_slot.last);
						err_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("top_k_weight_normalizer_top_tb: done, errors");
			$finish;
		end
	end

	task automatic push_beat(logic [JOINT_W-1:0] j, logic [WEIGHT_W-1:0] w,
			logic [JOINT_W-1:0] fb, logic last);
		weight_beat_t b;
		b.joint    = j;
		b.weight   = w;
		b.fallback = fb;
		b.last     = last;
		feed_q.insert(feed_q.size(), b);
		items_queued++;
		counted++;
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		logic [WEIGHT_W-1:0] w;
		w = {16'($urandom), 32'($urandom)};
		case ($urandom_range(9))
			0, 1: w = {32'd0, cur_min} + WEIGHT_W'($urandom_range(3));
			2: w = WEIGHT_W'($urandom_range(cur_min));
			3: w = prev_w;
			4, 5, 6: w = w >> $urandom_range(47);
			9: w = '1;
			default: ;
		endcase
		return w;
	endfunction

	task automatic queue_vertex();
		int unsigned len;
		logic [WEIGHT_W-1:0] w;
		len = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 7);
		for (int i = 0; i < len; i++) begin
			w = pick_weight();
			prev_w = w;
			push_beat(6'($urandom), w, 6'($urandom), i == len - 1);
		end
	endtask

	// hold until every beat is in and every slot is out
	task automatic wait_drain();
		while (!(items_fed == items_queued && slot_expect_q.size() == 0)) begin
			@(posedge clk);
		end
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_INFLUENCES_USED) begin
			cur_k = val[KCFG_W-1:0];
		end else begin
			cur_min = val;
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [KCFG_W-1:0]     k_set [6];
		logic [CFG_DATA_W-1:0] min_set [6];
		cur_k   = INFLUENCES_RESET;
		cur_min = MIN_WEIGHT_RESET;
		kept_n  = 0;
		for (int s = 0; s < MAX_INF; s++) begin
			kept_w[s] = '0;
			kept_j[s] = '0;
		end
		k_set   = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
		min_set = '{16'd0, 16'hFFFF, 16'd1, 16'd300, 16'($urandom), 16'd1};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// one full-scale weight on the top joint
		push_beat(6'd63, '1, 6'd0, 1'b1);
		// nothing above the threshold: fallback binds
		push_beat(6'd5, 48'd0, 6'd1, 1'b0);
		push_beat(6'd6, 48'd1, 6'd2, 1'b0);
		push_beat(6'd7, 48'd1, 6'd63, 1'b1);
		// ties keep arrival order, the fifth weight falls off
		push_beat(6'd1, 48'd100, 6'd0, 1'b0);
		push_beat(6'd2, 48'd300, 6'd0, 1'b0);
		push_beat(6'd3, 48'd100, 6'd0, 1'b0);
		push_beat(6'd4, 48'd300, 6'd0, 1'b0);
		push_beat(6'd5, 48'd50, 6'd7, 1'b1);
		// just above the threshold, shares round down and up
		push_beat(6'd0, 48'd2, 6'd0, 1'b0);
		push_beat(6'd9, 48'd3, 6'd0, 1'b1);
		// exact halves round up
		push_beat(6'd10, 48'd3, 6'd0, 1'b0);
		push_beat(6'd11, 48'd131069, 6'd0, 1'b1);
		// a lone weight of zero on joint zero
		push_beat(6'd0, 48'd0, 6'd0, 1'b1);
		// stronger weight arriving late displaces the weakest
		push_beat(6'd20, 48'h0000_0100_0000, 6'd0, 1'b0);
		push_beat(6'd21, 48'h0000_0200_0000, 6'd0, 1'b0);
		push_beat(6'd22, 48'h0000_0300_0000, 6'd0, 1'b0);
		push_beat(6'd23, 48'h0000_0400_0000, 6'd0, 1'b0);
		push_beat(6'd24, 48'h8000_0000_0000, 6'd0, 1'b1);
		wait_drain();
		counted = 0;

		for (int p = 0; p < 6; p++) begin
			write_reg(REG_INFLUENCES_USED, {13'd0, k_set[p]});
			write_reg(REG_MIN_WEIGHT, min_set[p]);
			settings++;
			src_idle_pct = (p == 2) ? 0 : 30;
			snk_idle_pct = (p == 2) ? 0 : 30;
			while (counted < PHASE_ITEMS * (p + 1)) begin
				queue_vertex();
			end
			wait_drain();
		end

		repeat (TAIL_GAP) @(posedge clk);
		if (slot_expect_q.size() != 0) begin
			$error("%0d slot beats never arrived", slot_expect_q.size());
			err_count++;
		end
		$display("run covered %0d weight beats over %0d vertices, %0d slot beats checked,",
			items_fed, vertices, slots_seen);
		$display("under %0d register settings including k clamping and both threshold extremes",
			settings);
		if (err_count == 0) begin
			$display("top_k_weight_normalizer_top_tb: done, clean");
		end else begin
			$display("top_k_weight_normalizer_top_tb: done, errors");
		end
		$finish;
	end

endmodule
